@@ hw/rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: field widths,
// opcodes, status codes and the result record.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int OP_W         = 2;
  localparam int POS_W        = 7;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                    success;
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic                    list_empty;
    logic [LEN_W-1:0]        list_length;
  } res_t;

endpackage

@@ hw/rtl/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = ple_pkg::VAL_W,
  parameter int DEPTH = ple_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ple_seq.sv @@
// ----------------------------------------------------------------------------
// ple_seq
// List sequencer: decodes one operation, walks the forward links, edits the
// node and link memories and the free-slot stack, and presents one result.
// ----------------------------------------------------------------------------
module ple_seq #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ple_pkg::OP_W-1:0]       in_opcode,
  input  logic [ple_pkg::POS_W-1:0]      in_position,
  input  logic signed [ple_pkg::VAL_W-1:0] in_item_value,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ple_pkg::res_t                  res
);

  import ple_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = IDX_W;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_INS_SLOT = 12'b0000_0000_0010,
    S_WALK     = 12'b0000_0000_0100,
    S_INS_NEXT = 12'b0000_0000_1000,
    S_INS_LINK = 12'b0000_0001_0000,
    S_INS_NODE = 12'b0000_0010_0000,
    S_INS_BACK = 12'b0000_0100_0000,
    S_DEL_READ = 12'b0000_1000_0000,
    S_DEL_LINK = 12'b0001_0000_0000,
    S_GET_READ = 12'b0010_0000_0000,
    S_GET_DATA = 12'b0100_0000_0000,
    S_FINISH   = 12'b1000_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0]        steps_r, steps_nxt;
  logic                    pend_r, pend_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [IDX_W-1:0]        prev_r, prev_nxt;
  logic [IDX_W-1:0]        next_r, next_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]        fc_r, fc_nxt;
  logic [CNT_W-1:0]        lw_r, lw_nxt;
  logic [IDX_W-1:0]        first_r, first_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ok_r, ok_nxt;
  status_t                 status_r, status_nxt;
  logic signed [VAL_W-1:0] rd_r, rd_nxt;

  logic                    val_we, fwd_we, bwd_we, free_we;
  logic [SLOT_W-1:0]       val_waddr, fwd_waddr, bwd_waddr, free_waddr;
  logic [VAL_W-1:0]        val_wdata, val_rd;
  logic [IDX_W-1:0]        fwd_wdata, bwd_wdata, fwd_rd, bwd_rd;
  logic [SLOT_W-1:0]       free_wdata, free_rd;
  logic [IDX_W-1:0]        head_sel;
  logic [CNT_W-1:0]        fc_dec;
  logic [CMP_W-1:0]        pos_c, cnt_c, get_c;
  logic [POS_W-1:0]        get_pos;

  assign head_sel = pend_r ? fwd_rd : cur_r;
  assign fc_dec   = fc_r - 1'b1;
  assign get_pos  = (in_position == '0) ? POS_W'(1) : in_position;
  assign pos_c    = CMP_W'(in_position);
  assign get_c    = CMP_W'(get_pos);
  assign cnt_c    = CMP_W'(cnt_r);

  ple_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (cur_r[SLOT_W-1:0]),
    .rdata (val_rd)
  );

  ple_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (head_sel[SLOT_W-1:0]),
    .rdata (fwd_rd)
  );

  ple_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_bwd_ram (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_waddr),
    .wdata (bwd_wdata),
    .raddr (cur_r[SLOT_W-1:0]),
    .rdata (bwd_rd)
  );

  ple_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (fc_dec[SLOT_W-1:0]),
    .rdata (free_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FINISH);

  always_comb begin
    res.success     = ok_r;
    res.status      = status_r;
    res.read_value  = rd_r;
    res.list_empty  = (cnt_r == '0);
    res.list_length = LEN_W'(cnt_r);
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    steps_nxt  = steps_r;
    pend_nxt   = 1'b0;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    next_nxt   = next_r;
    slot_nxt   = slot_r;
    fc_nxt     = fc_r;
    lw_nxt     = lw_r;
    first_nxt  = first_r;
    cnt_nxt    = cnt_r;
    ok_nxt     = ok_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;

    val_we     = 1'b0;
    val_waddr  = slot_r;
    val_wdata  = val_r;
    fwd_we     = 1'b0;
    fwd_waddr  = slot_r;
    fwd_wdata  = next_r;
    bwd_we     = 1'b0;
    bwd_waddr  = slot_r;
    bwd_wdata  = prev_r;
    free_we    = 1'b0;
    free_waddr = fc_r[SLOT_W-1:0];
    free_wdata = cur_r[SLOT_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt    = in_position;
          val_nxt    = in_item_value;
          cur_nxt    = first_r;
          ok_nxt     = 1'b0;
          status_nxt = ST_RANGE;
          rd_nxt     = '0;
          state_nxt  = S_FINISH;
          unique case (in_opcode)
            OP_INSERT: begin
              op_nxt = OP_INSERT;
              if (in_position != '0 && pos_c <= cnt_c + 1'b1) begin
                if (fc_r == '0) begin
                  status_nxt = ST_FULL;
                end else begin
                  ok_nxt     = 1'b1;
                  status_nxt = ST_OK;
                  state_nxt  = S_INS_SLOT;
                end
              end
            end
            OP_DELETE: begin
              op_nxt = OP_DELETE;
              if (in_position != '0 && pos_c <= cnt_c) begin
                ok_nxt     = 1'b1;
                status_nxt = ST_OK;
                steps_nxt  = in_position - 1'b1;
                state_nxt  = S_WALK;
              end
            end
            OP_GET: begin
              op_nxt = OP_GET;
              if (get_c <= cnt_c) begin
                ok_nxt     = 1'b1;
                status_nxt = ST_OK;
                steps_nxt  = get_pos - 1'b1;
                state_nxt  = S_WALK;
              end
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      S_INS_SLOT: begin
        if (fc_r == lw_r) begin
          slot_nxt = fc_dec[SLOT_W-1:0];
          lw_nxt   = fc_dec;
        end else begin
          slot_nxt = free_rd;
        end
        fc_nxt = fc_dec;
        if (pos_r == POS_W'(1)) begin
          prev_nxt  = NULL_IDX;
          next_nxt  = first_r;
          first_nxt = IDX_W'(slot_nxt);
          state_nxt = S_INS_NODE;
        end else begin
          steps_nxt = pos_r - POS_W'(2);
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (steps_r == '0) begin
          cur_nxt = head_sel;
          unique case (op_r)
            OP_INSERT: state_nxt = S_INS_NEXT;
            OP_DELETE: state_nxt = S_DEL_READ;
            default:   state_nxt = S_GET_READ;
          endcase
        end else begin
          pend_nxt  = 1'b1;
          steps_nxt = steps_r - 1'b1;
        end
      end

      S_INS_NEXT: begin
        state_nxt = S_INS_LINK;
      end

      S_INS_LINK: begin
        next_nxt  = fwd_rd;
        prev_nxt  = cur_r;
        fwd_we    = 1'b1;
        fwd_waddr = cur_r[SLOT_W-1:0];
        fwd_wdata = IDX_W'(slot_r);
        state_nxt = S_INS_NODE;
      end

      S_INS_NODE: begin
        val_we  = 1'b1;
        fwd_we  = 1'b1;
        bwd_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (next_r != NULL_IDX) ? S_INS_BACK : S_FINISH;
      end

      S_INS_BACK: begin
        bwd_we    = 1'b1;
        bwd_waddr = next_r[SLOT_W-1:0];
        bwd_wdata = IDX_W'(slot_r);
        state_nxt = S_FINISH;
      end

      S_DEL_READ: begin
        state_nxt = S_DEL_LINK;
      end

      S_DEL_LINK: begin
        if (bwd_rd != NULL_IDX) begin
          fwd_we    = 1'b1;
          fwd_waddr = bwd_rd[SLOT_W-1:0];
          fwd_wdata = fwd_rd;
        end else begin
          first_nxt = fwd_rd;
        end
        if (fwd_rd != NULL_IDX) begin
          bwd_we    = 1'b1;
          bwd_waddr = fwd_rd[SLOT_W-1:0];
          bwd_wdata = bwd_rd;
        end
        free_we   = 1'b1;
        fc_nxt    = fc_r + 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_FINISH;
      end

      S_GET_READ: begin
        state_nxt = S_GET_DATA;
      end

      S_GET_DATA: begin
        rd_nxt    = val_rd;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      fc_r    <= CNT_W'(CAPACITY);
      lw_r    <= CNT_W'(CAPACITY);
      first_r <= NULL_IDX;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      fc_r    <= fc_nxt;
      lw_r    <= lw_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    steps_r  <= steps_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    next_r   <= next_nxt;
    slot_r   <= slot_nxt;
    ok_r     <= ok_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
  end

endmodule

@@ hw/rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded doubly linked list of signed 32-bit values with insert, delete and
// get at a one-based position; one result per operation.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An operation walks the forward-link
// memory from the head, one node per cycle over its single read port. The
// result sits in an output register, so the next operation is taken while it
// waits. Slots come from a free stack in memory; never-used stack entries are
// tracked by a low-water mark, so no clearing pass follows reset.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ple_pkg::OP_W-1:0]         in_opcode,
  input  logic [ple_pkg::POS_W-1:0]        in_position,
  input  logic signed [ple_pkg::VAL_W-1:0] in_item_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_success,
  output logic [1:0]                       out_status,
  output logic signed [ple_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_list_empty,
  output logic [ple_pkg::LEN_W-1:0]        out_list_length
);

  import ple_pkg::*;

  logic res_valid, res_ready;
  res_t res;
  res_t out_r;
  logic out_valid_r;

  ple_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_position   (in_position),
    .in_item_value (in_item_value),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_r.success;
  assign out_status      = out_r.status;
  assign out_read_value  = out_r.read_value;
  assign out_list_empty  = out_r.list_empty;
  assign out_list_length = out_r.list_length;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of positional_list_engine. A directed opening
// covers empty-list access, rejected positions, head, middle and tail
// inserts and deletes, the value extremes and the unused opcode. Random
// bursts then grow, drain and mix the list, including runs into a full store,
// with noise items spread among them. Both channels idle at random. Every
// transfer is checked, field by field, against a positional list model.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  class list_result_board;
    logic signed [VAL_W-1:0] elems[$];
    res_t                    outcomes[$];
    int                      errors;

    function new();
      errors = 0;
    endfunction

    function int held();
      return elems.size();
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    function void note_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] val);
      res_t        r;
      int unsigned len;
      int unsigned p;
      len          = elems.size();
      r.success    = 1'b0;
      r.status     = ST_RANGE;
      r.read_value = '0;
      case (op)
        OP_INSERT: begin
          if (pos >= 1 && pos <= len + 1) begin
            if (len == LIST_CAP) begin
              r.status = ST_FULL;
            end else begin
              elems.insert(pos - 1, val);
              r.success = 1'b1;
              r.status  = ST_OK;
            end
          end
        end
        OP_DELETE: begin
          if (pos >= 1 && pos <= len) begin
            elems.delete(pos - 1);
            r.success = 1'b1;
            r.status  = ST_OK;
          end
        end
        OP_GET: begin
          p = (pos == 0) ? 1 : pos;
          if (p <= len) begin
            r.read_value = elems[p - 1];
            r.success    = 1'b1;
            r.status     = ST_OK;
          end
        end
        default: begin
        end
      endcase
      r.list_empty  = (elems.size() == 0);
      r.list_length = LEN_W'(elems.size());
      outcomes.push_back(r);
    endfunction

    function void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
        errors++;
        $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input res_t got);
      res_t want;
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: expected none actual length %0d",
                 $time, got.list_length);
        return;
      end
      want = outcomes.pop_front();
      check_field("success", want.success, got.success);
      check_field("status", want.status, got.status);
      check_field("read_value", want.read_value, got.read_value);
      check_field("list_empty", want.list_empty, got.list_empty);
      check_field("list_length", want.list_length, got.list_length);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_opcode = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_success;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    out_list_empty;
  logic [LEN_W-1:0]        out_list_length;

  bit                      calm = 1'b0;
  list_result_board        board = new();

  positional_list_engine #(.CAPACITY(LIST_CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_success     (out_success),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_list_empty  (out_list_empty),
    .out_list_length (out_list_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("positional_list_engine regression: fail");
    $finish;
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [VAL_W-1:0] val);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_position   <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_op(op, pos, val);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_burst(input int mode, input int count);
    int          len;
    int          roll;
    logic [1:0]  op;
    logic [6:0]  pos;
    for (int i = 0; i < count; i++) begin
      len  = board.held();
      roll = $urandom_range(99);
      if ($urandom_range(99) < 15) begin
        op  = 2'($urandom_range(3));
        pos = 7'($urandom_range(127));
      end else begin
        case (mode)
          0:       op = (roll < 75) ? OP_INSERT : (roll < 85) ? OP_DELETE : OP_GET;
          1:       op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_DELETE : OP_GET;
          default: op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE : OP_GET;
        endcase
        case (op)
          OP_INSERT: pos = 7'($urandom_range(len + 1, 1));
          OP_DELETE: pos = (len == 0) ? 7'd1 : 7'($urandom_range(len, 1));
          default:   pos = (len == 0 || $urandom_range(9) == 0) ? 7'd0
                                                                 : 7'($urandom_range(len, 1));
        endcase
      end
      send_op(op, pos, pick_value());
    end
  endtask

  initial begin
    int sent;
    int burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_GET,    7'd1,   32'sd0);
    send_op(OP_GET,    7'd0,   32'sd0);
    send_op(OP_DELETE, 7'd1,   32'sd0);
    send_op(OP_DELETE, 7'd0,   32'sd0);
    send_op(OP_INSERT, 7'd0,   32'sd5);
    send_op(OP_INSERT, 7'd2,   32'sd6);
    send_op(OP_INSERT, 7'd1,   32'sh7fff_ffff);
    send_op(OP_INSERT, 7'd1,   32'sh8000_0000);
    send_op(OP_INSERT, 7'd3,   -32'sd1);
    send_op(OP_INSERT, 7'd2,   32'sh5555_5555);
    send_op(OP_INSERT, 7'd127, 32'shaaaa_aaaa);
    send_op(OP_GET,    7'd0,   32'sd0);
    send_op(OP_GET,    7'd4,   32'sd0);
    send_op(OP_GET,    7'd5,   32'sd0);
    send_op(OP_GET,    7'd127, 32'sd0);
    send_op(OP_UNUSED, 7'd1,   -32'sd1);
    send_op(OP_DELETE, 7'd5,   32'sd0);
    send_op(OP_DELETE, 7'd2,   32'sd0);
    send_op(OP_DELETE, 7'd3,   32'sd0);
    send_op(OP_DELETE, 7'd1,   32'sd0);
    send_op(OP_GET,    7'd2,   32'sd0);
    send_op(OP_DELETE, 7'd1,   32'sd0);
    send_op(OP_DELETE, 7'd1,   32'sd0);
    send_op(OP_GET,    7'd0,   32'sd0);

    sent = 0;
    while (sent < 1000) begin
      burst = $urandom_range(120, 30);
      calm  = (sent >= 350 && sent < 550);
      run_burst($urandom_range(2), burst);
      sent += burst;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

  initial begin
    res_t got;
    wait (rst_n);
    forever begin
      out_ready <= calm || ($urandom_range(99) >= 36);
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.success     = out_success;
        got.status      = status_t'(out_status);
        got.read_value  = out_read_value;
        got.list_empty  = out_list_empty;
        got.list_length = out_list_length;
        board.check_result(got);
      end
    end
  end

endmodule
